// ===== rtl/core/ray_segment_nearest_hit_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef RAY_SEGMENT_NEAREST_HIT_ASSERT_SVH
`define RAY_SEGMENT_NEAREST_HIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSNH_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");
`define RSNH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSNH_ASSERT(label, cond)
`define RSNH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/rsnh_pkg.sv =====
package rsnh_pkg;

   localparam int COORD_W       = 32;
   localparam int DIR_W         = 18;
   localparam int DIR_FRAC_BITS = 16;
   localparam int QUO_W         = 32;
   localparam int DEN_W         = 52;
   localparam int DN_W          = 67;
   localparam int NUM_W         = DN_W + DIR_FRAC_BITS + 1;

   localparam logic [DEN_W-1:0] PARALLEL_MAX = 52'd4;
   localparam logic [DEN_W-1:0] TOL_LIMIT    = 52'd4194304;
   localparam logic [DEN_W-1:0] BILLION      = 52'd1000000000;
   localparam logic [31:0]      INF_CODE     = 32'hFFFF_FFFF;

   localparam logic [31:0] RANGE_MIN_RESET = 32'd6554;
   localparam logic [31:0] RANGE_MAX_RESET = 32'd786432;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_CAST   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam logic [1:0] REG_RANGE_MIN = 2'd0;
   localparam logic [1:0] REG_RANGE_MAX = 2'd1;
   localparam logic [1:0] REG_MISS_INF  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
   } seg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [DIR_W-1:0]   dx;
      logic signed [DIR_W-1:0]   dy;
   } ray_type;

endpackage

// ===== rtl/core/rsnh_req_if.sv =====
interface rsnh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic signed [31:0] seg_ax;
   logic signed [31:0] seg_ay;
   logic signed [31:0] seg_bx;
   logic signed [31:0] seg_by;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [17:0] dir_x;
   logic signed [17:0] dir_y;

   modport source (output valid, action, seg_ax, seg_ay, seg_bx, seg_by, origin_x, origin_y,
      dir_x, dir_y, input ready);
   modport sink (input valid, action, seg_ax, seg_ay, seg_bx, seg_by, origin_x, origin_y,
      dir_x, dir_y, output ready);
endinterface

// ===== rtl/core/rsnh_rsp_if.sv =====
interface rsnh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance;
   logic        hit;
   logic [1:0]  status;

   modport source (output valid, distance, hit, status, input ready);
   modport sink (input valid, distance, hit, status, output ready);
endinterface

// ===== rtl/core/rsnh_csr_if.sv =====
interface rsnh_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsnh_seg_mem.sv =====
module rsnh_seg_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  rsnh_pkg::seg_type          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output rsnh_pkg::seg_type          rd_data
);

   rsnh_pkg::seg_type mem [DEPTH];
   rsnh_pkg::seg_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rsnh_hit_calc.sv =====
module rsnh_hit_calc (
   input  logic                            clock,
   input  logic                            reset,
   input  rsnh_pkg::tag_type               tag_in,
   input  rsnh_pkg::seg_type               seg,
   input  rsnh_pkg::ray_type               ray,
   output rsnh_pkg::tag_type               tag_out,
   output logic                            ok_out,
   output logic [rsnh_pkg::NUM_W-1:0]      num_out,
   output logic [rsnh_pkg::DEN_W-1:0]      den_out
);

   localparam int DW = rsnh_pkg::DEN_W;
   localparam int NW = rsnh_pkg::DN_W;
   localparam int UW = rsnh_pkg::NUM_W;

   rsnh_pkg::tag_type tag_a_ff, tag_b_ff, tag_c_ff, tag_d_ff;

   logic signed [32:0] sx_in, sy_in, rx_in, ry_in;
   logic signed [32:0] sx_ff, sy_ff, rx_ff, ry_ff;

   logic signed [50:0] pd1_in, pd2_in, pt1_in, pt2_in;
   logic signed [50:0] pd1_ff, pd2_ff, pt1_ff, pt2_ff;
   logic signed [65:0] pn1_in, pn2_in, pn1_ff, pn2_ff;

   logic signed [DW-1:0] den_in, tn_in, den_ff, tn_ff;
   logic signed [NW-1:0] dn_in, dn_ff;

   logic                 neg;
   logic [DW-1:0]        dm;
   logic signed [DW-1:0] tn_n;
   logic signed [NW-1:0] dn_n;
   logic [DW-1:0]        ntn;
   logic signed [DW:0]   e;
   logic [DW-1:0]        eu;
   logic                 parallel, behind, tn_low, tn_high, ovf;
   logic [UW-1:0]        num;
   logic                 ok_in;

   logic                 ok_ff;
   logic [UW-1:0]        num_ff;
   logic [DW-1:0]        dm_ff;

   always_comb begin
      sx_in = 33'(seg.bx) - 33'(seg.ax);
      sy_in = 33'(seg.by) - 33'(seg.ay);
      rx_in = 33'(seg.ax) - 33'(ray.ox);
      ry_in = 33'(seg.ay) - 33'(ray.oy);
   end

   always_comb begin
      pd1_in = 51'(ray.dx) * 51'(sy_ff);
      pd2_in = 51'(ray.dy) * 51'(sx_ff);
      pt1_in = 51'(rx_ff) * 51'(ray.dy);
      pt2_in = 51'(ry_ff) * 51'(ray.dx);
      pn1_in = 66'(rx_ff) * 66'(sy_ff);
      pn2_in = 66'(ry_ff) * 66'(sx_ff);
   end

   always_comb begin
      den_in = DW'(pd1_ff) - DW'(pd2_ff);
      tn_in  = DW'(pt1_ff) - DW'(pt2_ff);
      dn_in  = NW'(pn1_ff) - NW'(pn2_ff);
   end

   // Signs are folded so that the denominator is non-negative before the tests.
   always_comb begin
      neg      = den_ff[DW-1];
      dm       = neg ? DW'(-den_ff) : DW'(den_ff);
      tn_n     = neg ? -tn_ff : tn_ff;
      dn_n     = neg ? -dn_ff : dn_ff;
      parallel = dm <= rsnh_pkg::PARALLEL_MAX;
      behind   = dn_n[NW-1];
      ntn      = DW'(-tn_n);
      tn_low   = tn_n[DW-1] && ((ntn >= rsnh_pkg::TOL_LIMIT) ||
                 ((DW'(ntn[21:0]) * rsnh_pkg::BILLION) > dm));
      e        = (DW+1)'(tn_n) - $signed({1'b0, dm});
      eu       = e[DW-1:0];
      tn_high  = !e[DW] && (e != '0) && ((eu >= rsnh_pkg::TOL_LIMIT) ||
                 ((DW'(eu[21:0]) * rsnh_pkg::BILLION) > dm));
      num      = {1'b0, dn_n, {rsnh_pkg::DIR_FRAC_BITS{1'b0}}};
      ovf      = num >= UW'({dm, {rsnh_pkg::QUO_W{1'b0}}});
      ok_in    = !parallel && !behind && !tn_low && !tn_high && !ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
         tag_d_ff <= '0;
      end else begin
         tag_a_ff <= tag_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
         tag_d_ff <= tag_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      pd1_ff <= pd1_in;
      pd2_ff <= pd2_in;
      pt1_ff <= pt1_in;
      pt2_ff <= pt2_in;
      pn1_ff <= pn1_in;
      pn2_ff <= pn2_in;
      den_ff <= den_in;
      tn_ff  <= tn_in;
      dn_ff  <= dn_in;
      ok_ff  <= ok_in;
      num_ff <= num;
      dm_ff  <= dm;
   end

   assign tag_out = tag_d_ff;
   assign ok_out  = ok_ff;
   assign num_out = num_ff;
   assign den_out = dm_ff;

endmodule

// ===== rtl/core/rsnh_divider.sv =====
module rsnh_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  rsnh_pkg::tag_type               tag_in,
   input  logic                            ok_in,
   input  logic [rsnh_pkg::NUM_W-1:0]      num_in,
   input  logic [rsnh_pkg::DEN_W-1:0]      den_in,
   output rsnh_pkg::tag_type               tag_out,
   output logic                            ok_out,
   output logic [rsnh_pkg::QUO_W-1:0]      quo_out
);

   localparam int QW = rsnh_pkg::QUO_W;
   localparam int UW = rsnh_pkg::NUM_W;
   localparam int DW = rsnh_pkg::DEN_W;

   rsnh_pkg::tag_type tag_ff [QW+1];
   logic              ok_ff  [QW+1];
   logic [UW-1:0]     num_ff [QW+1];
   logic [DW-1:0]     den_ff [QW+1];
   logic [QW-1:0]     quo_ff [QW+1];

   logic [UW-1:0]     shd    [QW];
   logic              take   [QW];

   // One quotient bit per stage, most significant first.
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         shd[k]  = UW'(den_ff[k]) << (QW - 1 - k);
         take[k] = num_ff[k] >= shd[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         tag_ff[0] <= tag_in;
         for (int k = 0; k < QW; k++) begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff[0]  <= ok_in;
      num_ff[0] <= num_in;
      den_ff[0] <= den_in;
      quo_ff[0] <= '0;
      for (int k = 0; k < QW; k++) begin
         ok_ff[k+1]  <= ok_ff[k];
         den_ff[k+1] <= den_ff[k];
         num_ff[k+1] <= take[k] ? (num_ff[k] - shd[k]) : num_ff[k];
         quo_ff[k+1] <= take[k] ? (quo_ff[k] | (QW'(1) << (QW - 1 - k))) : quo_ff[k];
      end
   end

   assign tag_out = tag_ff[QW];
   assign ok_out  = ok_ff[QW];
   assign quo_out = quo_ff[QW];

endmodule

// ===== rtl/core/ray_segment_nearest_hit.sv =====
// Channel   Direction  Handshake      Carries
// req_ch    in         valid/ready    action, segment ends, ray origin and direction
// rsp_ch    out        valid/ready    distance, hit, status
// csr_ch    in         valid/ready    register index and write data
//
// The result of a clear or append item is registered the next cycle.
// A cast item with N stored segments runs as a scan: the table memory
// delivers one segment per cycle into a 4-stage intersection pipeline and a
// 33-stage divider, and the scan ends when the last segment leaves the divider.
// Reset empties the table at once; there is no clearing pass.
// A new item is accepted only when the block is idle and the previous result is taken.
`include "ray_segment_nearest_hit_assert.svh"

module ray_segment_nearest_hit #(
   parameter int MAX_SEGMENTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   rsnh_req_if.sink            req_ch,
   rsnh_rsp_if.source          rsp_ch,
   rsnh_csr_if.sink            csr_ch
);

   localparam int AW    = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   rsnh_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic [31:0]      rmin_ff, rmax_ff;
   logic             inf_ff;
   logic             found_ff;
   logic [31:0]      best_ff;
   rsnh_pkg::ray_type ray_ff;

   logic             rsp_valid_ff;
   logic [31:0]      rsp_distance_ff;
   logic             rsp_hit_ff;
   logic [1:0]       rsp_status_ff;

   logic req_ready, rd_en, req_fire, rsp_fire, full, issue_last, wr_en, fin, cand, found_nx;
   logic [31:0] best_nx, miss_value;

   rsnh_pkg::seg_type wr_seg, rd_seg;
   rsnh_pkg::tag_type tag_m_ff, tag_c, tag_d;
   logic                         ok_c, ok_d;
   logic [rsnh_pkg::NUM_W-1:0]   num_c;
   logic [rsnh_pkg::DEN_W-1:0]   den_c;
   logic [rsnh_pkg::QUO_W-1:0]   quo_d;

   assign req_fire   = req_ch.valid && req_ready;
   assign rsp_fire   = rsp_valid_ff && rsp_ch.ready;
   assign full       = count_ff == CNT_W'(MAX_SEGMENTS);
   assign issue_last = (CNT_W'(rd_addr_ff) + CNT_W'(1)) == count_ff;
   assign wr_en      = req_fire && (req_ch.action == rsnh_pkg::ACT_APPEND) && !full;
   assign miss_value = inf_ff ? rsnh_pkg::INF_CODE : rmax_ff;

   always_comb begin
      wr_seg.ax = req_ch.seg_ax;
      wr_seg.ay = req_ch.seg_ay;
      wr_seg.bx = req_ch.seg_bx;
      wr_seg.by = req_ch.seg_by;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsnh_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.action == rsnh_pkg::ACT_CAST) && (count_ff != '0)) begin
               state_in = rsnh_pkg::ST_SCAN;
            end
         end
         rsnh_pkg::ST_SCAN: begin
            if (issue_last) begin
               state_in = rsnh_pkg::ST_WAIT;
            end
         end
         rsnh_pkg::ST_WAIT: begin
            if (fin) begin
               state_in = rsnh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsnh_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         rsnh_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff;
         end
         rsnh_pkg::ST_SCAN: begin
            rd_en = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
            rd_en     = 1'b0;
         end
      endcase
   end

   rsnh_seg_mem #(
      .DEPTH (MAX_SEGMENTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_seg),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_seg)
   );

   rsnh_hit_calc u_calc (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_m_ff),
      .seg     (rd_seg),
      .ray     (ray_ff),
      .tag_out (tag_c),
      .ok_out  (ok_c),
      .num_out (num_c),
      .den_out (den_c)
   );

   rsnh_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_c),
      .ok_in   (ok_c),
      .num_in  (num_c),
      .den_in  (den_c),
      .tag_out (tag_d),
      .ok_out  (ok_d),
      .quo_out (quo_d)
   );

   always_comb begin
      fin      = tag_d.valid && tag_d.last;
      cand     = tag_d.valid && ok_d && (quo_d >= rmin_ff) && (quo_d <= rmax_ff) &&
                 (!found_ff || (quo_d < best_ff));
      found_nx = found_ff || cand;
      best_nx  = cand ? quo_d : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsnh_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_addr_ff   <= '0;
         rmin_ff      <= rsnh_pkg::RANGE_MIN_RESET;
         rmax_ff      <= rsnh_pkg::RANGE_MAX_RESET;
         inf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tag_m_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         tag_m_ff.valid <= rd_en;
         tag_m_ff.last  <= rd_en && issue_last;
         if (csr_ch.valid) begin
            if (csr_ch.index == rsnh_pkg::REG_RANGE_MIN) begin
               rmin_ff <= csr_ch.data;
            end else if (csr_ch.index == rsnh_pkg::REG_RANGE_MAX) begin
               rmax_ff <= csr_ch.data;
            end else if (csr_ch.index == rsnh_pkg::REG_MISS_INF) begin
               inf_ff <= csr_ch.data[0];
            end
         end
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_en) begin
            rd_addr_ff <= rd_addr_ff + AW'(1);
         end
         if (tag_d.valid) begin
            found_ff <= found_nx;
         end
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end
         if (req_fire) begin
            case (req_ch.action)
               rsnh_pkg::ACT_CLEAR: begin
                  count_ff     <= '0;
                  rsp_valid_ff <= 1'b1;
               end
               rsnh_pkg::ACT_APPEND: begin
                  if (!full) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  rsp_valid_ff <= 1'b1;
               end
               rsnh_pkg::ACT_CAST: begin
                  rd_addr_ff   <= '0;
                  found_ff     <= 1'b0;
                  rsp_valid_ff <= count_ff == '0;
               end
               default: begin
                  rsp_valid_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tag_d.valid) begin
         best_ff <= best_nx;
      end
      if (fin) begin
         rsp_distance_ff <= found_nx ? best_nx : miss_value;
         rsp_hit_ff      <= found_nx;
         rsp_status_ff   <= rsnh_pkg::STAT_OK;
      end
      if (req_fire) begin
         rsp_distance_ff <= '0;
         rsp_hit_ff      <= 1'b0;
         rsp_status_ff   <= rsnh_pkg::STAT_OK;
         if ((req_ch.action == rsnh_pkg::ACT_APPEND) && full) begin
            rsp_status_ff <= rsnh_pkg::STAT_FULL;
         end
         if (req_ch.action == rsnh_pkg::ACT_CAST) begin
            rsp_distance_ff <= miss_value;
            rsp_status_ff   <= rsnh_pkg::STAT_EMPTY;
            ray_ff.ox       <= req_ch.origin_x;
            ray_ff.oy       <= req_ch.origin_y;
            ray_ff.dx       <= req_ch.dir_x;
            ray_ff.dy       <= req_ch.dir_y;
         end
      end
   end

   assign req_ch.ready    = req_ready;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_distance_ff;
   assign rsp_ch.hit      = rsp_hit_ff;
   assign rsp_ch.status   = rsp_status_ff;

   `RSNH_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_SEGMENTS))
   `RSNH_ASSERT(a_read_below_count, !rd_en || (CNT_W'(rd_addr_ff) < count_ff))
   `RSNH_ASSERT(a_fin_during_cast, !fin || (state_ff == rsnh_pkg::ST_WAIT))
   `RSNH_ASSERT_NEXT(a_req_answered, req_fire, rsp_valid_ff || (state_ff == rsnh_pkg::ST_SCAN))

endmodule
